>>> sv/rwmf_pkg.sv
// Package for the RGB window median filter: pixel widths, size limits,
// register indexes and the control tag that travels with a pixel.
// Depends on nothing; every module of the block imports it.
package rwmf_pkg;

   localparam int PIX_W        = 8;
   localparam int RGB_W        = 3 * PIX_W;
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_RADIUS = 3;
   localparam int CFG_W        = 12;
   localparam int CSR_IDX_W    = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RADIUS = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } csr_index_type;

   // Tag carried beside a pixel through the line buffer.
   typedef struct packed {
      logic valid;
      logic emit;
      logic last;
   } ctl_type;

endpackage

>>> sv/rwmf_channels.sv
// Handshake channel interfaces of the RGB window median filter.
// No dependencies; included after the package.
interface rwmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;
   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface rwmf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] med_red;
   logic [7:0] med_green;
   logic [7:0] med_blue;
   logic       frame_end;
   modport source (output valid, med_red, med_green, med_blue, frame_end, input ready);
   modport sink (input valid, med_red, med_green, med_blue, frame_end, output ready);
endinterface

interface rwmf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [11:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/rgb_window_median_filter.sv
// RGB window median filter, top level.
// Depends on rwmf_pkg, the channel interfaces, rwmf_line_buffer and rwmf_median_lane.
//
// Pixels enter in raster order on req_chan, one request per pixel. For every
// interior pixel the block returns on rsp_chan the median of the square window
// of side 2*radius+1, taken per color, and sets frame_end on the result of the
// last interior pixel of the frame. Border pixels produce no result.
// The csr_chan port writes radius, frame_width and frame_height; any write to
// one of them restarts the frame at row 0, column 0. It is ready whenever the
// block is out of reset.
// Throughput is one pixel per cycle while the receiver does not stall. The result
// for a window reaches the output register through the line store read on the
// edge that accepts the request holding its bottom-right pixel, then the window
// shift, the bit-per-stage rank search of the three color lanes, and the output
// register.
// The line store is a single-port-per-direction memory with one read and one
// write per cycle, one word per column holding the previous rows.
// Reset clears the counters, the valid bits of the pipeline and the registers
// to radius 1, 640 by 480; no request or register write is taken during reset.
// The line store needs no clearing since a window never reaches rows the
// current frame has not written.
// When the receiver stalls, the whole pipeline holds and req_chan.ready drops
// while a result waits in the output register.
module rgb_window_median_filter #(
   parameter int MAX_WIDTH  = rwmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = rwmf_pkg::DEF_MAX_RADIUS
) (
   input logic         clock,
   input logic         reset,
   rwmf_req_if.sink    req_chan,
   rwmf_rsp_if.source  rsp_chan,
   rwmf_csr_if.sink    csr_chan
);
   import rwmf_pkg::*;

   localparam int S   = 2 * MAX_RADIUS + 1;
   localparam int N   = S * S;
   localparam int RW  = $clog2(N + 1);
   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int WW  = AW + 1;
   localparam int LAT = PIX_W;

   // Configuration registers.
   logic [1:0]       radius_ff;
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;

   // Raster position of the next pixel.
   logic [AW-1:0]    col_ff, col_in;
   logic [CFG_W-1:0] row_ff, row_in;

   logic [1:0]       v_eff;
   logic [WW-1:0]    w_eff;
   logic [CFG_W-1:0] h_eff;
   logic             en;
   logic             acc;
   ctl_type          in_ctl;
   ctl_type          win_ctl;
   logic [RGB_W-1:0] win [S][S];

   logic [N-1:0]     alive;
   logic [RW-1:0]    rank;
   logic [PIX_W-1:0] lane_val [3][N];
   logic [PIX_W-1:0] lane_med [3];

   logic [LAT-1:0]   vld_line_ff;
   logic [LAT-1:0]   last_line_ff;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff;
   logic             end_ff;

   // Out-of-range settings are folded into the nearest legal value.
   always_comb begin
      if (radius_ff == 2'd0) v_eff = 2'd1;
      else if (int'(radius_ff) > MAX_RADIUS) v_eff = 2'(MAX_RADIUS);
      else v_eff = radius_ff;
      if (width_ff == '0) w_eff = WW'(1);
      else if (int'(width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_ff);
      h_eff = (height_ff == '0) ? CFG_W'(1) : height_ff;
   end

   // The pipeline moves whenever the output register is free or being emptied.
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en && !reset;
   assign acc            = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = !reset;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (WW'(col_ff) + WW'(1) >= w_eff) begin
            col_in = '0;
            row_in = ({1'b0, row_ff} + 13'd1 >= {1'b0, h_eff}) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      in_ctl.valid = acc;
      in_ctl.emit  = (row_ff >= CFG_W'({v_eff, 1'b0})) && (WW'(col_ff) >= WW'({v_eff, 1'b0}));
      in_ctl.last  = (row_ff == h_eff - 1'b1) && (WW'(col_ff) == w_eff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 2'd1;
         width_ff  <= CFG_W'(640);
         height_ff <= CFG_W'(480);
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_chan.valid) begin
         col_ff <= col_in;
         row_ff <= row_in;
         case (csr_chan.index)
            REG_RADIUS: begin
               radius_ff <= csr_chan.data[1:0];
               col_ff    <= '0;
               row_ff    <= '0;
            end
            REG_WIDTH: begin
               width_ff <= csr_chan.data;
               col_ff   <= '0;
               row_ff   <= '0;
            end
            REG_HEIGHT: begin
               height_ff <= csr_chan.data;
               col_ff    <= '0;
               row_ff    <= '0;
            end
            default: begin
            end
         endcase
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   rwmf_line_buffer #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .pix     ({req_chan.in_red, req_chan.in_green, req_chan.in_blue}),
      .col     (col_ff),
      .in_ctl  (in_ctl),
      .win     (win),
      .out_ctl (win_ctl)
   );

   // Only the newest 2*radius+1 rows and columns of the window take part;
   // the median sits at rank 2*v*(v+1) counted from zero.
   always_comb begin
      rank = RW'(2 * int'(v_eff) * (int'(v_eff) + 1));
      for (int d = 0; d < S; d++) begin
         for (int k = 0; k < S; k++) begin
            alive[d*S+k]       = (d <= 2 * int'(v_eff)) && (k <= 2 * int'(v_eff));
            lane_val[0][d*S+k] = win[d][k][2*PIX_W +: PIX_W];
            lane_val[1][d*S+k] = win[d][k][PIX_W +: PIX_W];
            lane_val[2][d*S+k] = win[d][k][0 +: PIX_W];
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      rwmf_median_lane #(
         .N  (N),
         .RW (RW)
      ) u_lane (
         .clock    (clock),
         .en       (en),
         .in_val   (lane_val[l]),
         .in_alive (alive),
         .in_rank  (rank),
         .med      (lane_med[l])
      );
   end

   // Valid and frame-end tags follow the lanes stage by stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_line_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_line_ff  <= {vld_line_ff[LAT-2:0], win_ctl.valid};
         rsp_valid_ff <= vld_line_ff[LAT-1];
      end
   end

   // The merge stage gathers the three lane medians into one result.
   always_ff @(posedge clock) begin
      if (en) begin
         last_line_ff <= {last_line_ff[LAT-2:0], win_ctl.last};
         red_ff       <= lane_med[0];
         green_ff     <= lane_med[1];
         blue_ff      <= lane_med[2];
         end_ff       <= last_line_ff[LAT-1];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.med_red   = red_ff;
   assign rsp_chan.med_green = green_ff;
   assign rsp_chan.med_blue  = blue_ff;
   assign rsp_chan.frame_end = end_ff;

   // The raster position never passes the frame size in force.
   a_col_bound : assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < w_eff) else $error("column past frame width");

   a_row_bound : assert property (@(posedge clock) disable iff (reset)
      row_ff < h_eff) else $error("row past frame height");

   // A waiting result blocks new requests.
   a_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while result stalled");

   // A request accepted with no configuration write, short of the row's last column, advances the column by one.
   a_step : assert property (@(posedge clock) disable iff (reset)
      acc && !csr_chan.valid && (WW'(col_ff) + WW'(1) < w_eff)
      |=> col_ff == $past(col_ff) + 1'b1)
      else $error("column did not advance");

endmodule

>>> sv/rwmf_line_buffer.sv
// Line store and sliding pixel window of the median filter.
// Depends on rwmf_pkg for pixel widths and the control tag.
module rwmf_line_buffer #(
   parameter int MAX_WIDTH  = rwmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = rwmf_pkg::DEF_MAX_RADIUS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic [rwmf_pkg::RGB_W-1:0]        pix,
   input  logic [$clog2(MAX_WIDTH)-1:0]      col,
   input  rwmf_pkg::ctl_type                 in_ctl,
   output logic [rwmf_pkg::RGB_W-1:0]        win [2*MAX_RADIUS+1][2*MAX_RADIUS+1],
   output rwmf_pkg::ctl_type                 out_ctl
);
   import rwmf_pkg::*;

   localparam int S    = 2 * MAX_RADIUS + 1;
   localparam int ROWS = 2 * MAX_RADIUS;
   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int LW   = ROWS * RGB_W;

   // Each word holds one column of the previous rows, newest row in the low slot.
   logic [LW-1:0]    mem [MAX_WIDTH];
   logic [LW-1:0]    rd_ff;
   logic [LW-1:0]    wb_ff;
   logic             same_ff;
   logic [RGB_W-1:0] pix_ff;
   logic [AW-1:0]    col_ff;
   ctl_type          ctl_ff;
   ctl_type          win_ctl_ff;
   logic [RGB_W-1:0] win_ff [S][S];

   logic [LW-1:0]    old_word;
   logic [LW-1:0]    new_word;
   logic [RGB_W-1:0] column [S];

   always_comb begin
      old_word = same_ff ? wb_ff : rd_ff;
      new_word = {old_word[LW-RGB_W-1:0], pix_ff};
      column[0] = pix_ff;
      for (int d = 1; d < S; d++) begin
         column[d] = old_word[(d-1)*RGB_W +: RGB_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (in_ctl.valid) begin
            rd_ff <= mem[col];
         end
         if (ctl_ff.valid) begin
            mem[col_ff] <= new_word;
         end
         // A read that meets a write to the same column is bypassed to the newly written word.
         same_ff <= ctl_ff.valid && (col == col_ff);
         wb_ff   <= new_word;
         pix_ff  <= pix;
         col_ff  <= col;
      end
   end

   always_ff @(posedge clock) begin
      if (en && ctl_ff.valid) begin
         for (int d = 0; d < S; d++) begin
            win_ff[d][0] <= column[d];
            for (int k = 1; k < S; k++) begin
               win_ff[d][k] <= win_ff[d][k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff     <= '0;
         win_ctl_ff <= '0;
      end else if (en) begin
         ctl_ff           <= in_ctl;
         win_ctl_ff.valid <= ctl_ff.valid && ctl_ff.emit;
         win_ctl_ff.emit  <= ctl_ff.emit;
         win_ctl_ff.last  <= ctl_ff.last;
      end
   end

   assign win     = win_ff;
   assign out_ctl = win_ctl_ff;

endmodule

>>> sv/rwmf_median_lane.sv
// One color lane of the median: a bitwise rank search, one bit per stage.
// Depends on rwmf_pkg for the pixel width.
module rwmf_median_lane #(
   parameter int N  = 9,
   parameter int RW = 4
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [rwmf_pkg::PIX_W-1:0] in_val [N],
   input  logic [N-1:0]               in_alive,
   input  logic [RW-1:0]              in_rank,
   output logic [rwmf_pkg::PIX_W-1:0] med
);
   import rwmf_pkg::*;

   // The last stage needs no copy of the values, so there is one fewer.
   logic [PIX_W-1:0] val_ff   [PIX_W-1][N];
   logic [N-1:0]     alive_ff [PIX_W];
   logic [RW-1:0]    rank_ff  [PIX_W];
   logic [PIX_W-1:0] med_ff   [PIX_W];

   for (genvar s = 0; s < PIX_W; s++) begin : g_stage
      localparam int B = PIX_W - 1 - s;
      logic [PIX_W-1:0] v_in [N];
      logic [N-1:0]     a_in;
      logic [RW-1:0]    k_in;
      logic [PIX_W-1:0] m_in;
      logic [RW-1:0]    zeros;
      logic [N-1:0]     a_out;
      logic [RW-1:0]    k_out;
      logic [PIX_W-1:0] m_out;

      if (s == 0) begin : g_first
         assign v_in = in_val;
         assign a_in = in_alive;
         assign k_in = in_rank;
         assign m_in = '0;
      end else begin : g_next
         assign v_in = val_ff[s-1];
         assign a_in = alive_ff[s-1];
         assign k_in = rank_ff[s-1];
         assign m_in = med_ff[s-1];
      end

      always_comb begin
         zeros = '0;
         for (int i = 0; i < N; i++) begin
            zeros = zeros + RW'(a_in[i] && !v_in[i][B]);
         end
         m_out = m_in;
         if (k_in < zeros) begin
            m_out[B] = 1'b0;
            k_out    = k_in;
            for (int i = 0; i < N; i++) a_out[i] = a_in[i] && !v_in[i][B];
         end else begin
            m_out[B] = 1'b1;
            k_out    = k_in - zeros;
            for (int i = 0; i < N; i++) a_out[i] = a_in[i] && v_in[i][B];
         end
      end

      if (s < PIX_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               val_ff[s] <= v_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            alive_ff[s] <= a_out;
            rank_ff[s]  <= k_out;
            med_ff[s]   <= m_out;
         end
      end
   end

   assign med = med_ff[PIX_W-1];

endmodule
